/* design/mel_pkg.sv */
// ----------------------------------------------------------------------------
// mel_pkg: shared types and constants of the mouse event ring log
// Store geometry, record layout, opcodes, result kinds and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mel_pkg;

  localparam int EVENT_DEPTH = 64;                      // power of two, 2..64
  localparam int IDX_W       = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
  localparam int TOTAL_W     = 7;
  localparam int REC_W       = 160;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 168;

  // first member lands in the highest bits, so move_x sits at bit 0
  typedef struct packed {
    logic [63:0]        time_stamp;
    logic [31:0]        raw_buttons;
    logic [15:0]        button_data;
    logic [15:0]        button_flags;
    logic signed [15:0] move_y;
    logic signed [15:0] move_x;
  } rec_t;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_FORWARD = 2'd0,
    KIND_CONSUME = 2'd1,
    KIND_DUMP    = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVT,
    S_CLR,
    S_EMPTY,
    S_DRD,
    S_DOUT
  } state_e;

  typedef struct packed {
    logic capture_in;    // latch the input payload
    logic ev_commit;     // store event, emit its result
    logic clr_commit;    // reset indices, emit ack
    logic empty_commit;  // emit record-less dump result
    logic dump_start;    // set up read index and counts
    logic dump_read;     // issue store read
    logic dump_emit;     // emit the record just read
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic held_zero;     // store holds nothing
    logic dump_last;     // current dump record is the final one
  } dp_stat_t;

endpackage

/* design/mel_ram.sv */
// ----------------------------------------------------------------------------
// mel_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mel_datapath.sv */
// ----------------------------------------------------------------------------
// mel_datapath: storage, pointers and output register
// Holds the event store, write pointer, held count, dump walk counters,
// the capture register and the result register facing the output stream.
// ----------------------------------------------------------------------------
module mel_datapath
  import mel_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_stat_t               stat_o,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_data_i,
  input  logic                   out_tready_i,
  output logic                   out_tvalid_o,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic [2:0]             out_tuser_o,
  output logic                   out_tlast_o
);

  rec_t             in_rec_q;
  logic [IDX_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             capture_q;
  logic [REC_W-1:0] ram_rdata;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  kind_e            out_kind_q, out_kind_d;
  logic             out_has_q, out_has_d;
  rec_t             out_rec_q, out_rec_d;
  logic [CNT_W-1:0] out_total_q, out_total_d;
  logic             out_last_q, out_last_d;

  mel_ram #(
    .WIDTH (REC_W),
    .DEPTH (EVENT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ev_commit),
    .waddr_i (wp_q),
    .wdata_i (in_rec_q),
    .re_i    (cmd_i.dump_read),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      in_rec_q <= rec_t'(in_tdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_q <= 1'b0;
    end else if (cfg_valid_i) begin
      capture_q <= cfg_data_i;
    end
  end

  always_comb begin
    wp_d     = wp_q;
    held_d   = held_q;
    rd_idx_d = rd_idx_q;
    remain_d = remain_q;
    total_d  = total_q;
    if (cmd_i.ev_commit) begin
      wp_d = wp_q + 1'b1;
      if (held_q != CNT_W'(EVENT_DEPTH)) begin
        held_d = held_q + 1'b1;
      end
    end
    if (cmd_i.clr_commit) begin
      wp_d   = '0;
      held_d = '0;
    end
    if (cmd_i.dump_start) begin
      // oldest entry sits held_count slots behind the write pointer
      rd_idx_d = wp_q - held_q[IDX_W-1:0];
      remain_d = held_q;
      total_d  = held_q;
    end
    if (cmd_i.dump_emit) begin
      rd_idx_d = rd_idx_q + 1'b1;
      remain_d = remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      held_q   <= '0;
      rd_idx_q <= '0;
      remain_q <= '0;
      total_q  <= '0;
    end else begin
      wp_q     <= wp_d;
      held_q   <= held_d;
      rd_idx_q <= rd_idx_d;
      remain_q <= remain_d;
      total_q  <= total_d;
    end
  end

  // output register
  assign out_load = cmd_i.ev_commit | cmd_i.clr_commit | cmd_i.empty_commit
                  | cmd_i.dump_emit;

  always_comb begin
    out_kind_d  = out_kind_q;
    out_has_d   = out_has_q;
    out_rec_d   = out_rec_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q & ~out_tready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_has_d   = 1'b0;
      out_rec_d   = '0;
      out_total_d = '0;
      out_last_d  = 1'b1;
      out_kind_d  = KIND_CLEAR;
      if (cmd_i.ev_commit) begin
        out_kind_d = capture_q ? KIND_CONSUME : KIND_FORWARD;
        out_has_d  = 1'b1;
        out_rec_d  = in_rec_q;
      end else if (cmd_i.empty_commit) begin
        out_kind_d = KIND_DUMP;
      end else if (cmd_i.dump_emit) begin
        out_kind_d  = KIND_DUMP;
        out_has_d   = 1'b1;
        out_rec_d   = rec_t'(ram_rdata);
        out_total_d = total_q;
        out_last_d  = stat_o.dump_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_has_q   <= out_has_d;
    out_rec_q   <= out_rec_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  assign stat_o.out_free  = ~out_valid_q | out_tready_i;
  assign stat_o.held_zero = (held_q == '0);
  assign stat_o.dump_last = (remain_q == CNT_W'(1));

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {1'b0, TOTAL_W'(out_total_q), out_rec_q};
  assign out_tuser_o  = {out_has_q, out_kind_q};
  assign out_tlast_o  = out_last_q;

endmodule

/* design/mel_ctrl.sv */
// ----------------------------------------------------------------------------
// mel_ctrl: sequencing controller
// Accepts one item at a time, decodes its opcode and steps the datapath
// through store, clear or the record-by-record dump walk.
// ----------------------------------------------------------------------------
module mel_ctrl
  import mel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_tvalid_i,
  input  logic [1:0] in_tuser_i,
  output logic       in_tready_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.capture_in = 1'b1;
          unique case (op_e'(in_tuser_i))
            OP_EVENT: state_d = S_EVT;
            OP_CLEAR: state_d = S_CLR;
            OP_DUMP: begin
              if (stat_i.held_zero) begin
                state_d = S_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = S_DRD;
              end
            end
            default: state_d = S_IDLE;   // unused opcode: dropped
          endcase
        end
      end
      S_EVT: begin
        if (stat_i.out_free) begin
          cmd_o.ev_commit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CLR: begin
        if (stat_i.out_free) begin
          cmd_o.clr_commit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.empty_commit = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.dump_read = 1'b1;
        state_d         = S_DOUT;
      end
      S_DOUT: begin
        if (stat_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          state_d         = stat_i.dump_last ? S_IDLE : S_DRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/mouse_event_ring_log_unit.sv */
// Timing: an event or clear item is captured, then committed into the result
// register once the output is free; a dump walks each record oldest first
// through a store read and then the result register, stalling while the output is busy.
// Throughput: one item at a time; a new one is taken only after the last is done.
// Reset: pointers, held count, capture bit and valids clear; store contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// mouse_event_ring_log_unit: overwriting circular mouse event log
// Stores events in a wrapping store, forwards or consumes them, dumps the
// held records oldest first and clears on request.
// ----------------------------------------------------------------------------
module mouse_event_ring_log_unit
  import mel_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // fields low to high: move_x, move_y, button_flags, button_data,
  // raw_buttons, time_stamp
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,   // opcode
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fields low to high: out_move_x, out_move_y, out_button_flags,
  // out_button_data, out_raw_buttons, out_time_stamp, record_total, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]             m_axis_tuser,   // kind, has_record
  output logic                   m_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i      // capture_enable
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  mel_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tuser_i  (s_axis_tuser),
    .in_tready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mel_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_tdata_i   (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser),
    .out_tlast_o  (m_axis_tlast)
  );

endmodule
